### rtl/bf_optimized_instruction_executor_core_assert.svh
// assertion macros shared by the checker of the tape-machine executor
// needs nothing else; included by the checker file only
`ifndef BF_OPTIMIZED_INSTRUCTION_EXECUTOR_CORE_ASSERT_SVH
`define BF_OPTIMIZED_INSTRUCTION_EXECUTOR_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define BFX_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("bfx assertion failed");

// condition holds in the cycle after the trigger
`define BFX_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("bfx assertion failed");

`endif

### rtl/bfx_pkg.sv
// shared constants, codes and types of the tape-machine executor
// no dependencies; imported by the core, the divider and the test benches
package bfx_pkg;

   // sizing of the tape, the program and the cells
   localparam int TAPE_DEPTH    = 32768;
   localparam int PROGRAM_DEPTH = 65536;
   localparam int CELL_BITS     = 8;
   localparam int TAPE_ADDR_W   = $clog2(TAPE_DEPTH);
   localparam int TAPE_LAST     = TAPE_DEPTH - 1;
   localparam int IDX_W         = $clog2(PROGRAM_DEPTH);

   // field widths of the request, response and csr
   localparam int TYPE_W      = 4;
   localparam int OFFSET_W    = 16;
   localparam int AMOUNT_W    = 8;
   localparam int COUNT_W     = 8;
   localparam int PARTNER_W   = 16;
   localparam int BYTE_W      = 8;
   localparam int NEXT_W      = 16;
   localparam int FAULT_W     = 2;
   localparam int LIMIT_W     = 15;
   localparam int LIMIT_RESET = 32767;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 3;
   localparam int CSR_DATA_W  = 16;

   // signed target offset width, room for sign and carry
   localparam int TGT_W = ((TAPE_ADDR_W > OFFSET_W) ? TAPE_ADDR_W : OFFSET_W) + 2;

   // divider sizing: dividend is the cell shifted up by a cell width
   localparam int DIV_STEPS = 2 * CELL_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [TYPE_W-1:0] {
      OP_MOVE   = 4'd0,
      OP_ADD    = 4'd1,
      OP_MULADD = 4'd2,
      OP_CLEAR  = 4'd3,
      OP_WRITE  = 4'd4,
      OP_READ   = 4'd5,
      OP_LOOPB  = 4'd6,
      OP_LOOPE  = 4'd7,
      OP_NOP    = 4'd8
   } op_code_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_TARGET    = 2'd3
   } fault_type;

   // divider command and status
   typedef struct packed {
      logic                   start;
      logic [DIV_STEPS-1:0]   dividend;
      logic [COUNT_W-1:0]     divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                   done;
      logic [CELL_BITS-1:0]   quotient;
   } div_stat_type;

endpackage

### rtl/bf_optimized_instruction_executor_core.sv
// Tape-machine instruction executor: one decoded instruction per request.
// Request channel req_*: req_tuser carries the operation code, req_tdata the
// offset, amount, underflow count, loop partner and read byte. Each request
// gives exactly one response on rsp_*: next index, emitted byte, fault code.
// csr_* writes the tape limit; it is always ready. It is to be written while
// idle; the block does not enforce this. After reset a clearing pass writes
// zero to all 32768 tape cells, one per cycle; req_tready is low meanwhile.
// Flow: a request is taken, the current cell is read from the tape ram
// (registered read), the operation is executed and the response is placed
// in the output register. A multiply-add then reads and writes a second
// cell through the same ram port; when underflow_count is above 1 the
// divider first runs its 16 steps to form the correction. A request met
// while halted skips the tape and is answered with the held index.
// The block works on one request at a time and takes no request until the
// previous one is finished. A stalled response sits in the output register
// and holds the block in its last state until rsp_tready is high.
// A fault halts the block until the next reset.
module bf_optimized_instruction_executor_core (
   input  logic                           clock,
   input  logic                           reset,
   // request: tuser = req_type [3:0]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: offset_arg [15:0], amount_arg [23:16], underflow_count [31:24],
   //        loop_partner [47:32], read_byte [55:48]
   input  logic [bfx_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bfx_pkg::TYPE_W-1:0]     req_tuser,
   // response
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: next_index [15:0], out_byte [23:16]
   output logic [bfx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: out_valid [0], fault [2:1]
   output logic [bfx_pkg::RSP_USER_W-1:0] rsp_tuser,
   // csr write: tdata = tape_limit [14:0], bit 15 unused
   input  logic                           csr_tvalid,
   output logic                           csr_tready,
   input  logic [bfx_pkg::CSR_DATA_W-1:0] csr_tdata
);

   import bfx_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_DIVIDE,
      ST_TFETCH,
      ST_TUPDATE,
      ST_DONE
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [TAPE_ADDR_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic                   halted_ff, halted_in;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   logic [TAPE_ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // request and result payload
   logic [TYPE_W-1:0]       type_ff, type_in;
   logic signed [OFFSET_W-1:0] offs_ff, offs_in;
   logic signed [AMOUNT_W-1:0] amount_ff, amount_in;
   logic [COUNT_W-1:0]      ucount_ff, ucount_in;
   logic [PARTNER_W-1:0]    partner_ff, partner_in;
   logic [BYTE_W-1:0]       rbyte_ff, rbyte_in;
   logic [TAPE_ADDR_W-1:0]  target_ff, target_in;
   logic [CELL_BITS-1:0]    left_ff, left_in;
   logic [IDX_W-1:0]        res_index_ff, res_index_in;
   logic                    res_out_ff, res_out_in;
   logic [BYTE_W-1:0]       res_byte_ff, res_byte_in;
   fault_type               res_fault_ff, res_fault_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   // tape ram ports
   logic                   wr_en;
   logic [TAPE_ADDR_W-1:0] wr_addr;
   logic [CELL_BITS-1:0]   wr_data;
   logic                   rd_en;
   logic [TAPE_ADDR_W-1:0] rd_addr;
   logic [CELL_BITS-1:0]   rd_data;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   // datapath helpers
   logic signed [TGT_W-1:0] tgt_calc;
   logic [TGT_W-1:0]        lim_wide;
   logic                    tgt_neg;
   logic                    tgt_over;
   logic [IDX_W-1:0]        idx_step;
   logic [IDX_W-1:0]        idx_jump;
   logic [CELL_BITS-1:0]    amt_ext;
   logic [2*CELL_BITS-1:0]  prod_full;
   logic                    slot_free;

   bfx_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfx_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .div_stat (div_stat)
   );

   // target cell, range check against the effective limit
   always_comb begin
      tgt_calc = TGT_W'(ptr_ff) + TGT_W'(offs_ff);
      lim_wide = (TGT_W'(limit_ff) > TGT_W'(TAPE_LAST)) ? TGT_W'(TAPE_LAST)
                                                         : TGT_W'(limit_ff);
      tgt_neg  = tgt_calc[TGT_W-1];
      tgt_over = !tgt_neg && ($unsigned(tgt_calc) > lim_wide);
      idx_step = index_ff + IDX_W'(1);
      idx_jump = IDX_W'(partner_ff) + IDX_W'(1);
      amt_ext  = CELL_BITS'(amount_ff);
      prod_full = left_ff * amt_ext;
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      index_in     = index_ff;
      halted_in    = halted_ff;
      limit_in     = limit_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      type_in      = type_ff;
      offs_in      = offs_ff;
      amount_in    = amount_ff;
      ucount_in    = ucount_ff;
      partner_in   = partner_ff;
      rbyte_in     = rbyte_ff;
      target_in    = target_ff;
      left_in      = left_ff;
      res_index_in = res_index_ff;
      res_out_in   = res_out_ff;
      res_byte_in  = res_byte_ff;
      res_fault_in = res_fault_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = {rd_data, {CELL_BITS{1'b0}}};
      div_ctrl.divisor  = ucount_ff;

      // tape limit register
      if (csr_tvalid) begin
         limit_in = csr_tdata[LIMIT_W-1:0];
      end

      // response taken by the receiver
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + TAPE_ADDR_W'(1);
            if (clr_addr_ff == TAPE_ADDR_W'(TAPE_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               type_in      = req_tuser;
               offs_in      = req_tdata[15:0];
               amount_in    = req_tdata[23:16];
               ucount_in    = req_tdata[31:24];
               partner_in   = req_tdata[47:32];
               rbyte_in     = req_tdata[55:48];
               res_index_in = index_ff;
               res_out_in   = 1'b0;
               res_byte_in  = '0;
               res_fault_in = FAULT_NONE;
               state_in     = halted_ff ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // default: advance by one and answer
            res_index_in = idx_step;
            index_in     = idx_step;
            state_in     = ST_DONE;
            unique case (type_ff)
               OP_MOVE: begin
                  if (tgt_neg || tgt_over) begin
                     res_index_in = index_ff;
                     index_in     = index_ff;
                     halted_in    = 1'b1;
                     res_fault_in = tgt_neg ? FAULT_UNDERFLOW : FAULT_OVERFLOW;
                  end else begin
                     ptr_in = tgt_calc[TAPE_ADDR_W-1:0];
                  end
               end
               OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data + amt_ext;
               end
               OP_MULADD: begin
                  target_in = tgt_calc[TAPE_ADDR_W-1:0];
                  if (tgt_neg || tgt_over) begin
                     res_index_in = index_ff;
                     index_in     = index_ff;
                     halted_in    = 1'b1;
                     res_fault_in = FAULT_TARGET;
                  end else if (ucount_ff > COUNT_W'(1)) begin
                     div_ctrl.start = 1'b1;
                     state_in       = ST_DIVIDE;
                  end else begin
                     left_in  = rd_data;
                     state_in = ST_TFETCH;
                  end
               end
               OP_CLEAR: begin
                  wr_en   = 1'b1;
                  wr_data = '0;
               end
               OP_WRITE: begin
                  res_out_in  = 1'b1;
                  res_byte_in = rd_data[BYTE_W-1:0];
               end
               OP_READ: begin
                  wr_en   = 1'b1;
                  wr_data = CELL_BITS'(rbyte_ff);
               end
               OP_LOOPB: begin
                  if (rd_data == '0) begin
                     res_index_in = idx_jump;
                     index_in     = idx_jump;
                  end
               end
               OP_LOOPE: begin
                  if (rd_data != '0) begin
                     res_index_in = idx_jump;
                     index_in     = idx_jump;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIVIDE: begin
            // ceiling correction: 2^cell - floor(cell * 2^cell / count)
            if (div_stat.done) begin
               left_in  = CELL_BITS'(0) - div_stat.quotient;
               state_in = ST_TFETCH;
            end
         end
         ST_TFETCH: begin
            rd_en    = 1'b1;
            rd_addr  = target_ff;
            state_in = ST_TUPDATE;
         end
         ST_TUPDATE: begin
            wr_en    = 1'b1;
            wr_addr  = target_ff;
            wr_data  = rd_data + prod_full[CELL_BITS-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_byte_ff, NEXT_W'(res_index_ff)};
               rsp_user_in  = {res_fault_ff, res_out_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         index_ff     <= '0;
         halted_ff    <= 1'b0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         index_ff     <= index_in;
         halted_ff    <= halted_in;
         limit_ff     <= limit_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff      <= type_in;
      offs_ff      <= offs_in;
      amount_ff    <= amount_in;
      ucount_ff    <= ucount_in;
      partner_ff   <= partner_in;
      rbyte_ff     <= rbyte_in;
      target_ff    <= target_in;
      left_ff      <= left_in;
      res_index_ff <= res_index_in;
      res_out_ff   <= res_out_in;
      res_byte_ff  <= res_byte_in;
      res_fault_ff <= res_fault_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // port drive
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_tready = 1'b1;

endmodule

### rtl/bfx_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies; holds the tape cells
module bfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfx_div_unit.sv
// restoring divider, one quotient bit per cycle
// depends on bfx_pkg; gives the low cell bits of the quotient
module bfx_div_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  bfx_pkg::div_ctrl_type div_ctrl,
   output bfx_pkg::div_stat_type div_stat
);

   import bfx_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_STEPS-1:0] dvd_ff, dvd_in;
   logic [COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [CELL_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_W:0]     trial;
   logic                 fits;

   // one shift, compare and subtract step
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_STEPS-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = div_ctrl.dividend;
         dsr_in  = div_ctrl.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_STEPS-2:0], 1'b0};
         quo_in = {quo_ff[CELL_BITS-2:0], fits};
         rem_in = fits ? COUNT_W'(trial - {1'b0, dsr_ff}) : trial[COUNT_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_stat.done     = done_ff;
   assign div_stat.quotient = quo_ff;

endmodule

### rtl/bfx_checker.sv
// port-level checks of the tape-machine executor, bound to the top level
// depends on bf_optimized_instruction_executor_core_assert.svh
`include "bf_optimized_instruction_executor_core_assert.svh"

module bfx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled response holds
   `BFX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // the byte field is zero unless a byte is emitted
   `BFX_ASSERT_NOW(a_byte_only_on_write, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[23:16] == 8'h00)

   // an emitted byte never comes with a fault
   `BFX_ASSERT_NOW(a_no_byte_on_fault, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tuser[2:1] == 2'b00)

   // one request at a time: busy right after a request is taken
   `BFX_ASSERT_NEXT(a_busy_after_request, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind bf_optimized_instruction_executor_core bfx_checker u_checker (.*);

### test/tape_exec_checker.sv
// checker for the tape-machine executor: watches the request, response and csr
// channels, predicts each response and compares it; depends on rtl/bfx_pkg.sv
`timescale 1ns / 1ps

module tape_exec_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bfx_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bfx_pkg::TYPE_W-1:0]     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bfx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [bfx_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_tvalid,
   input  logic                           csr_tready,
   input  logic [bfx_pkg::CSR_DATA_W-1:0] csr_tdata,
   output int                             failures,
   output int                             outstanding
);

   import bfx_pkg::*;

   localparam int CELL_SPAN   = 1 << CELL_BITS;
   localparam int SHOWN_LIMIT = 10;

   typedef struct packed {
      logic [NEXT_W-1:0]  next_index;
      logic               out_valid;
      logic [BYTE_W-1:0]  out_byte;
      logic [FAULT_W-1:0] fault;
   } step_outcome_type;

   // own copy of the machine state
   logic [CELL_BITS-1:0] tape_mem [0:TAPE_DEPTH-1];
   int                   cell_ptr;
   int                   limit_q;
   logic [IDX_W-1:0]     prog_index;
   logic                 halted;

   step_outcome_type expected_outcomes [$];

   // applies one instruction to the state and returns the response it gives
   function automatic step_outcome_type execute_instruction(
      input logic [TYPE_W-1:0]    op,
      input logic [OFFSET_W-1:0]  offset_raw,
      input logic [AMOUNT_W-1:0]  amount_raw,
      input logic [COUNT_W-1:0]   divisor,
      input logic [PARTNER_W-1:0] partner,
      input logic [BYTE_W-1:0]    in_byte
   );
      step_outcome_type     res;
      logic [CELL_BITS-1:0] cur;
      logic [CELL_BITS-1:0] correction;
      logic [IDX_W-1:0]     jump_from;
      int                   target;
      int                   div_i;
      int                   num;
      int                   quo;

      res.next_index = prog_index;
      res.out_valid  = 1'b0;
      res.out_byte   = '0;
      res.fault      = FAULT_NONE;
      if (halted)
         return res;

      cur       = tape_mem[cell_ptr];
      jump_from = prog_index;
      target    = cell_ptr + int'($signed(offset_raw));

      case (op)
         OP_MOVE: begin
            if (target < 0 || target > limit_q) begin
               halted = 1'b1;
               if (target < 0)
                  res.fault = FAULT_UNDERFLOW;
               else
                  res.fault = FAULT_OVERFLOW;
               return res;
            end
            cell_ptr = target;
         end
         OP_ADD: tape_mem[cell_ptr] = cur + amount_raw;
         OP_MULADD: begin
            if (target < 0 || target > limit_q) begin
               halted    = 1'b1;
               res.fault = FAULT_TARGET;
               return res;
            end
            // ceiling of span * (u - c) / u, truncating division rounds up below zero
            if (divisor > 1) begin
               div_i = divisor;
               num   = CELL_SPAN * (div_i - int'(cur));
               quo   = num / div_i;
               if (num > 0 && (num % div_i) != 0)
                  quo = quo + 1;
               correction = quo[CELL_BITS-1:0];
            end else begin
               correction = cur;
            end
            tape_mem[target] = tape_mem[target] + correction * amount_raw;
         end
         OP_CLEAR: tape_mem[cell_ptr] = '0;
         OP_WRITE: begin
            res.out_valid = 1'b1;
            res.out_byte  = cur;
         end
         OP_READ: tape_mem[cell_ptr] = in_byte;
         OP_LOOPB: begin
            if (cur == 0)
               jump_from = partner;
         end
         OP_LOOPE: begin
            if (cur != 0)
               jump_from = partner;
         end
         default: ;
      endcase

      prog_index     = jump_from + 1'b1;
      res.next_index = prog_index;
      return res;
   endfunction

   // compare responses first, then log the new request of the same edge
   always @(posedge clock) begin
      step_outcome_type seen;
      step_outcome_type want;

      if (reset) begin
         for (int i = 0; i < TAPE_DEPTH; i++)
            tape_mem[i] = '0;
         cell_ptr    = 0;
         limit_q     = LIMIT_RESET;
         prog_index  = '0;
         halted      = 1'b0;
         failures    = 0;
         outstanding = 0;
      end else begin
         if (csr_tvalid && csr_tready)
            limit_q = csr_tdata[LIMIT_W-1:0];

         if (rsp_tvalid && rsp_tready) begin
            seen.next_index = rsp_tdata[NEXT_W-1:0];
            seen.out_byte   = rsp_tdata[NEXT_W +: BYTE_W];
            seen.out_valid  = rsp_tuser[0];
            seen.fault      = rsp_tuser[FAULT_W:1];
            if (expected_outcomes.size() == 0) begin
               failures = failures + 1;
               if (failures <= SHOWN_LIMIT)
                  $display("%0t: unexpected response next_index %h fault %0d",
                           $realtime, seen.next_index, seen.fault);
            end else begin
               want = expected_outcomes.pop_front();
               if (seen !== want) begin
                  failures = failures + 1;
                  if (failures <= SHOWN_LIMIT)
                     $display(
                        "%0t: mismatch exp/act idx %h/%h valid %b/%b byte %h/%h fault %0d/%0d",
                        $realtime, want.next_index, seen.next_index,
                        want.out_valid, seen.out_valid, want.out_byte,
                        seen.out_byte, want.fault, seen.fault);
               end
            end
         end

         if (req_tvalid && req_tready)
            expected_outcomes.push_back(execute_instruction(
               req_tuser, req_tdata[15:0], req_tdata[23:16], req_tdata[31:24],
               req_tdata[47:32], req_tdata[55:48]));

         outstanding = expected_outcomes.size();
      end
   end

endmodule

### test/tb_bf_optimized_instruction_executor_core.sv
// testbench top for the tape-machine executor: clock, reset, request and csr
// stimulus and the verdict; checking is done by tape_exec_checker (test/)
`timescale 1ns / 1ps

module tb_bf_optimized_instruction_executor_core;
   import bfx_pkg::*;

   localparam logic [TYPE_W-1:0] OP_UNKNOWN_LO = 4'd9;
   localparam logic [TYPE_W-1:0] OP_UNKNOWN_HI = 4'd15;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int HALTED_ITEMS    = 12;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_tvalid = 1'b0;
   logic                  csr_tready;
   logic [CSR_DATA_W-1:0] csr_tdata  = '0;

   int          failures;
   int          outstanding;
   int unsigned cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   // where the pointer stands, so that random moves stay on the tape
   int   tape_pos    = 0;
   int   cur_limit   = LIMIT_RESET;
   logic has_faulted = 1'b0;

   bf_optimized_instruction_executor_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   tape_exec_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_tvalid  (csr_tvalid),
      .csr_tready  (csr_tready),
      .csr_tdata   (csr_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_tready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
   end

   // one request, with random idle cycles ahead of it
   task automatic issue_instruction(
      input logic [TYPE_W-1:0]    op,
      input logic [OFFSET_W-1:0]  offset,
      input logic [AMOUNT_W-1:0]  amount,
      input logic [COUNT_W-1:0]   divisor,
      input logic [PARTNER_W-1:0] partner,
      input logic [BYTE_W-1:0]    in_byte
   );
      int target;

      @(negedge clock);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {in_byte, partner, divisor, amount, offset};
      do @(posedge clock); while (!req_tready);

      // follow the pointer and note a fault
      if (!has_faulted && (op == OP_MOVE || op == OP_MULADD)) begin
         target = tape_pos + int'($signed(offset));
         if (target < 0 || target > cur_limit)
            has_faulted = 1'b1;
         else if (op == OP_MOVE)
            tape_pos = target;
      end
   endtask

   // a cell mostly close to the pointer, sometimes anywhere on the tape
   function automatic int pick_cell_near(input int radius, input int far_pct);
      int t;

      if (int'($urandom_range(0, 99)) < far_pct)
         return int'($urandom_range(0, cur_limit));
      t = tape_pos + int'($urandom_range(0, 2 * radius)) - radius;
      if (t < 0)
         t = 0;
      if (t > cur_limit)
         t = cur_limit;
      return t;
   endfunction

   // random instruction that keeps the pointer and targets on the tape
   task automatic issue_random_instruction();
      int                  r;
      logic [TYPE_W-1:0]   op;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  divisor;
      logic [BYTE_W-1:0]   in_byte;

      r = $urandom_range(0, 99);
      if (r < 20)      op = OP_MOVE;
      else if (r < 35) op = OP_ADD;
      else if (r < 50) op = OP_MULADD;
      else if (r < 57) op = OP_CLEAR;
      else if (r < 69) op = OP_WRITE;
      else if (r < 79) op = OP_READ;
      else if (r < 86) op = OP_LOOPB;
      else if (r < 93) op = OP_LOOPE;
      else if (r < 97) op = OP_NOP;
      else             op = TYPE_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));

      offset = OFFSET_W'($urandom);
      if (op == OP_MOVE)
         offset = 16'(pick_cell_near(4, 20) - tape_pos);
      else if (op == OP_MULADD)
         offset = 16'(pick_cell_near(3, 10) - tape_pos);

      // small divisors most of the time, the full range now and then
      r = $urandom_range(0, 99);
      if (r < 30)      divisor = COUNT_W'($urandom_range(0, 1));
      else if (r < 70) divisor = COUNT_W'($urandom_range(2, 8));
      else             divisor = COUNT_W'($urandom);

      in_byte = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      issue_instruction(op, offset, AMOUNT_W'($urandom), divisor, PARTNER_W'($urandom),
                        in_byte);
   endtask

   // lower valid, let every response arrive and the block settle
   task automatic wait_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_tape_limit(input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      do @(posedge clock); while (!csr_tready);
      @(negedge clock);
      csr_tvalid <= 1'b0;
      cur_limit = value[LIMIT_W-1:0];
   endtask

   initial begin
      fault_type           fault_kind;
      logic                upward;
      int                  reach;
      logic [OFFSET_W-1:0] escape_offset;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_tape_limit({1'($urandom), 15'(TAPE_LAST)});

      // empty cell: write, loop begin taken and wrapping, loop end falling through
      issue_instruction(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_LOOPB, $urandom, $urandom, $urandom, 16'hFFFF, $urandom);
      issue_instruction(OP_LOOPE, $urandom, $urandom, $urandom, 16'h0000, $urandom);
      // add extremes, the cell reaches all ones
      issue_instruction(OP_ADD, $urandom, 8'h7F, $urandom, $urandom, $urandom);
      issue_instruction(OP_ADD, $urandom, 8'h80, $urandom, $urandom, $urandom);
      issue_instruction(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      // non-zero cell: loop end taken and wrapping, loop begin falling through
      issue_instruction(OP_LOOPE, $urandom, $urandom, $urandom, 16'hFFFF, $urandom);
      issue_instruction(OP_LOOPB, $urandom, $urandom, $urandom, 16'h0000, $urandom);
      // multiply-add: plain copy, onto its own cell, then with the correction
      issue_instruction(OP_MULADD, 16'h0001, 8'h03, 8'd0, $urandom, $urandom);
      issue_instruction(OP_MULADD, 16'h0000, 8'hFF, 8'd1, $urandom, $urandom);
      issue_instruction(OP_READ, $urandom, $urandom, $urandom, $urandom, 8'h05);
      // cell above the divisor, then rounding up, then a quotient that is not exact
      issue_instruction(OP_MULADD, 16'h0001, 8'h80, 8'd2, $urandom, $urandom);
      issue_instruction(OP_MULADD, 16'h0002, 8'h7F, 8'd255, $urandom, $urandom);
      issue_instruction(OP_MULADD, 16'h0003, 8'h01, 8'd3, $urandom, $urandom);
      issue_instruction(OP_READ, $urandom, $urandom, $urandom, $urandom, 8'hFF);
      issue_instruction(OP_READ, $urandom, $urandom, $urandom, $urandom, 8'h00);
      issue_instruction(OP_MULADD, 16'h0001, 8'h07, 8'd128, $urandom, $urandom);
      issue_instruction(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      // pointer to the top cell and back to the bottom
      issue_instruction(OP_MOVE, 16'h7FFF, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_ADD, $urandom, 8'h01, $urandom, $urandom, $urandom);
      issue_instruction(OP_MULADD, 16'h0000, 8'h09, 8'd5, $urandom, $urandom);
      issue_instruction(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_MOVE, 16'h8001, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_MOVE, 16'h0000, $urandom, $urandom, $urandom, $urandom);
      // no-op and unknown codes
      issue_instruction(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_UNKNOWN_LO, $urandom, $urandom, $urandom, $urandom, $urandom);
      issue_instruction(OP_UNKNOWN_HI, $urandom, $urandom, $urandom, $urandom, $urandom);

      // random phases, each with its own idling and tape limit
      for (int ph = 0; ph < 4; ph++) begin
         wait_until_drained();
         case (ph)
            0: write_tape_limit({1'($urandom), 15'(TAPE_LAST)});
            1: write_tape_limit(16'($urandom));
            2: write_tape_limit({1'($urandom), 15'd0});
            default: write_tape_limit({1'($urandom), 15'($urandom_range(1, 63))});
         endcase
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         repeat (ITEMS_PER_PHASE) issue_random_instruction();
      end

      // one fault of a random kind, then requests while halted
      fault_kind = fault_type'($urandom_range(FAULT_UNDERFLOW, FAULT_TARGET));
      upward = (fault_kind == FAULT_OVERFLOW) ||
               (fault_kind == FAULT_TARGET && $urandom_range(0, 1) == 1);
      if (upward && cur_limit - tape_pos + 1 > TAPE_LAST)
         issue_instruction(OP_MOVE, 16'h0001, $urandom, $urandom, $urandom, $urandom);
      if (upward) begin
         reach = cur_limit - tape_pos + 1;
         escape_offset = 16'(reach + int'($urandom_range(0, TAPE_LAST - reach)));
      end else begin
         escape_offset = 16'(-tape_pos - 1 - int'($urandom_range(0, TAPE_LAST - tape_pos)));
      end
      issue_instruction((fault_kind == FAULT_TARGET) ? OP_MULADD : OP_MOVE, escape_offset,
                        $urandom, $urandom, $urandom, $urandom);
      repeat (HALTED_ITEMS) issue_random_instruction();

      wait_until_drained();
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bfx_pkg.sv
rtl/bfx_ram.sv
rtl/bfx_div_unit.sv
rtl/bf_optimized_instruction_executor_core.sv
rtl/bfx_checker.sv
test/tape_exec_checker.sv
test/tb_bf_optimized_instruction_executor_core.sv
